>>> rtl/ssc_pkg.sv
// Shared types, constants and helper functions of the scaled Sturm sign counter.
`default_nettype none

package ssc_pkg;

    // Default saturation limit of the eigenvalue count.
    localparam int unsigned MAX_ORDER_DEFAULT = 65535;

    // Width of the eigenvalue count.
    localparam int COUNT_W = 16;

    // Width of the internal signed exponent used by the floating-point unit.
    localparam int EXP_W = 14;

    // Double precision constants.
    localparam logic [63:0] FP_ONE        = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_SCALE_BIG  = 64'h4210_0000_0000_0000;  // 2^34
    localparam logic [63:0] FP_SCALE_TINY = 64'h3DD0_0000_0000_0000;  // 2^-34
    localparam logic [63:0] FP_QNAN       = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] FP_ZERO       = 64'h0000_0000_0000_0000;

    // Floating-point unit operations.
    typedef enum logic [1:0] {
        FP_ADD,
        FP_SUB,
        FP_MUL,
        FP_DIV
    } fp_op_t;

    // Operand sources of the floating-point unit.
    typedef enum logic [3:0] {
        OPND_D,
        OPND_E,
        OPND_T,
        OPND_U,
        OPND_TC,
        OPND_TP,
        OPND_SIGMA,
        OPND_W,
        OPND_K
    } opnd_t;

    // Destination of a floating-point unit result.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_T,
        DST_U,
        DST_TC,
        DST_TP
    } dst_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DSUB,
        ST_FIRST,
        ST_LEAD,
        ST_SQ,
        ST_TAIL,
        ST_FRESH,
        ST_ADVANCE,
        ST_SDIV,
        ST_SC1,
        ST_SC2,
        ST_COUNT,
        ST_FINISH
    } ctrl_state_t;

    // Floating-point unit states.
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PRENORM,
        FS_MUL,
        FS_MULEND,
        FS_DIV,
        FS_DIVEND,
        FS_NORM,
        FS_DONE
    } fpu_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   fpu_start;
        fp_op_t op;
        opnd_t  src_a;
        opnd_t  src_b;
        dst_t   dst;
        logic   first_set;
        logic   advance;
        logic   count_check;
        logic   emit;
        logic   mark_mid;
    } ssc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fpu_done;
        logic mid;
        logic last;
        logic need_scale;
        logic out_free;
    } ssc_status_t;

    // True for any NaN bit pattern.
    function automatic logic fp_is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    // True when the value compares strictly below zero.
    function automatic logic fp_lt_zero(input logic [63:0] x);
        return !fp_is_nan(x) && x[63] && (x[62:0] != 63'd0);
    endfunction

    // True when the value compares at or above zero.
    function automatic logic fp_ge_zero(input logic [63:0] x);
        return !fp_is_nan(x) && !fp_lt_zero(x);
    endfunction

endpackage

`default_nettype wire

>>> rtl/scaled_sturm_sign_counter_top.sv
// Top level of the scaled Sturm sequence sign counter.
// Rows that need rescaling take longer, and subnormal operands lengthen each multiply or divide.
// Throughput: one row at a time, set by the shared bit-serial multiply and divide unit.
// The count is loaded into the output register from the last row's final state, once that register is free.
// Reset clears all control state, the terms and the count; the shift point resets to +0.0.
`default_nettype none

module scaled_sturm_sign_counter_top #(
    parameter int unsigned MAX_ORDER = ssc_pkg::MAX_ORDER_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [63:0]            cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [63:0]            diag_value,
    input  wire logic [63:0]            offd_value,
    input  wire logic                   last_element,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [ssc_pkg::COUNT_W-1:0] below_count
);
    import ssc_pkg::*;

    ssc_cmd_t    cmd;
    ssc_status_t status;

    // Sequencer.
    ssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // Arithmetic and storage.
    ssc_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .diag_value   (diag_value),
        .offd_value   (offd_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .below_count  (below_count)
    );

endmodule

`default_nettype wire

>>> rtl/ssc_fpu.sv
// Multi-cycle double precision add, subtract, multiply and divide unit.
`default_nettype none

module ssc_fpu (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ssc_pkg::fp_op_t op,
    input  wire logic [63:0]    a,
    input  wire logic [63:0]    b,
    output logic                done,
    output logic [63:0]         result
);
    import ssc_pkg::*;

    fpu_state_t              state_reg, state_next;
    fp_op_t                  op_reg, op_next;
    logic                    sign_reg, sign_next;
    logic signed [EXP_W-1:0] ea_reg, ea_next;
    logic signed [EXP_W-1:0] eb_reg, eb_next;
    logic [52:0]             ma_reg, ma_next;
    logic [52:0]             mb_reg, mb_next;
    logic [105:0]            prod_reg, prod_next;
    logic [54:0]             rem_reg, rem_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [56:0]             m_reg, m_next;
    logic signed [EXP_W-1:0] be_reg, be_next;
    logic                    st_reg, st_next;
    logic [63:0]             res_reg, res_next;

    // Operand unpacking.
    logic [10:0]             a_exp, b_exp;
    logic                    a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [52:0]             a_mant, b_mant;
    logic signed [EXP_W-1:0] a_be, b_be;
    logic                    sb_eff, sx;

    assign a_exp  = a[62:52];
    assign b_exp  = b[62:52];
    assign a_zero = (a_exp == 11'd0) && (a[51:0] == 52'd0);
    assign b_zero = (b_exp == 11'd0) && (b[51:0] == 52'd0);
    assign a_inf  = (a_exp == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf  = (b_exp == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_nan  = fp_is_nan(a);
    assign b_nan  = fp_is_nan(b);
    assign a_mant = {a_exp != 11'd0, a[51:0]};
    assign b_mant = {b_exp != 11'd0, b[51:0]};
    assign a_be   = (a_exp == 11'd0) ? EXP_W'(1) : $signed({3'b000, a_exp});
    assign b_be   = (b_exp == 11'd0) ? EXP_W'(1) : $signed({3'b000, b_exp});
    assign sb_eff = b[63] ^ (op == FP_SUB);
    assign sx     = a[63] ^ b[63];

    // Special operands: NaN, infinity and zero.
    logic        special_hit;
    logic [63:0] special_res;

    always_comb
    begin
        special_hit = 1'b1;
        special_res = FP_QNAN;
        unique case (op) inside
            FP_ADD, FP_SUB:
            begin
                if (a_nan || b_nan)
                    special_res = FP_QNAN;
                else if (a_inf && b_inf)
                    special_res = (a[63] == sb_eff) ? {a[63], 11'h7FF, 52'd0} : FP_QNAN;
                else if (a_inf)
                    special_res = {a[63], 11'h7FF, 52'd0};
                else if (b_inf)
                    special_res = {sb_eff, 11'h7FF, 52'd0};
                else
                    special_hit = 1'b0;
            end
            FP_MUL:
            begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                    special_res = FP_QNAN;
                else if (a_inf || b_inf)
                    special_res = {sx, 11'h7FF, 52'd0};
                else if (a_zero || b_zero)
                    special_res = {sx, 63'd0};
                else
                    special_hit = 1'b0;
            end
            FP_DIV:
            begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
                    special_res = FP_QNAN;
                else if (a_inf || b_zero)
                    special_res = {sx, 11'h7FF, 52'd0};
                else if (b_inf || a_zero)
                    special_res = {sx, 63'd0};
                else
                    special_hit = 1'b0;
            end
            default:
            begin
                special_hit = 1'b1;
                special_res = FP_QNAN;
            end
        endcase
    end

    // Alignment and signed add of the two significands.
    logic                    swap, big_s, sml_s, lost, add_sign;
    logic [52:0]             big_m, sml_m;
    logic signed [EXP_W-1:0] big_be, sml_be, shamt;
    logic [56:0]             big_x, sml_x, al, al_st, add_m;
    logic [57:0]             sum58, diff58, neg58;

    always_comb
    begin
        swap   = (b_be > a_be);
        big_m  = swap ? b_mant : a_mant;
        sml_m  = swap ? a_mant : b_mant;
        big_s  = swap ? sb_eff : a[63];
        sml_s  = swap ? a[63] : sb_eff;
        big_be = swap ? b_be : a_be;
        sml_be = swap ? a_be : b_be;
        shamt  = big_be - sml_be;
        big_x  = {1'b0, big_m, 3'b000};
        sml_x  = {1'b0, sml_m, 3'b000};
        if (shamt > EXP_W'(56))
        begin
            al   = '0;
            lost = |sml_x;
        end
        else
        begin
            al   = sml_x >> shamt[5:0];
            lost = |(sml_x & ~({57{1'b1}} << shamt[5:0]));
        end
        al_st  = {al[56:1], al[0] | lost};
        sum58  = {1'b0, big_x} + {1'b0, al_st};
        diff58 = {1'b0, big_x} - {1'b0, al_st};
        neg58  = ~diff58 + 58'd1;
        if (big_s == sml_s)
        begin
            add_m    = sum58[56:0];
            add_sign = big_s;
        end
        else if (diff58[57])
        begin
            add_m    = neg58[56:0];
            add_sign = sml_s;
        end
        else
        begin
            add_m    = diff58[56:0];
            add_sign = (diff58 == 58'd0) ? 1'b0 : big_s;
        end
    end

    // Normalization decision and round to nearest even.
    logic                    norm_right, norm_left, norm_collapse, norm_finish;
    logic                    rnd_inc;
    logic [53:0]             rsum;
    logic signed [EXP_W-1:0] exp_out;
    logic [51:0]             frac_out;
    logic [63:0]             rounded;

    always_comb
    begin
        norm_right    = 1'b0;
        norm_left     = 1'b0;
        norm_collapse = 1'b0;
        norm_finish   = 1'b0;
        if (m_reg[56])
            norm_right = 1'b1;
        else if (be_reg < EXP_W'(1))
        begin
            if (be_reg < -EXP_W'(60))
                norm_collapse = 1'b1;
            else
                norm_right = 1'b1;
        end
        else if (!m_reg[55] && (be_reg > EXP_W'(1)) && (m_reg != 57'd0))
            norm_left = 1'b1;
        else
            norm_finish = 1'b1;

        rnd_inc = m_reg[2] & (m_reg[1] | m_reg[0] | st_reg | m_reg[3]);
        rsum    = {1'b0, m_reg[55:3]} + {53'd0, rnd_inc};
        if (rsum[53])
        begin
            exp_out  = be_reg + EXP_W'(1);
            frac_out = 52'd0;
        end
        else
        begin
            exp_out  = rsum[52] ? be_reg : EXP_W'(0);
            frac_out = rsum[51:0];
        end
        if (exp_out >= EXP_W'(2047))
            rounded = {sign_reg, 11'h7FF, 52'd0};
        else
            rounded = {sign_reg, exp_out[10:0], frac_out};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    if (special_hit)
                        state_next = FS_DONE;
                    else if ((op == FP_ADD) || (op == FP_SUB))
                        state_next = FS_NORM;
                    else
                        state_next = FS_PRENORM;
                end
            end
            FS_PRENORM:
            begin
                if (ma_reg[52] && mb_reg[52])
                    state_next = (op_reg == FP_MUL) ? FS_MUL : FS_DIV;
            end
            FS_MUL:
            begin
                if (cnt_reg == 6'd0)
                    state_next = FS_MULEND;
            end
            FS_MULEND:  state_next = FS_NORM;
            FS_DIV:
            begin
                if (cnt_reg == 6'd0)
                    state_next = FS_DIVEND;
            end
            FS_DIVEND:  state_next = FS_NORM;
            FS_NORM:
            begin
                if (norm_finish)
                    state_next = FS_DONE;
            end
            FS_DONE:    state_next = FS_IDLE;
            default:    state_next = FS_IDLE;
        endcase
    end

    // Datapath register updates for each state.
    logic        div_ge;
    logic [54:0] div_r1;

    always_comb
    begin
        op_next   = op_reg;
        sign_next = sign_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        be_next   = be_reg;
        st_next   = st_reg;
        res_next  = res_reg;
        div_ge    = (rem_reg >= {2'b00, mb_reg});
        div_r1    = div_ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    res_next = special_res;
                    ma_next  = a_mant;
                    mb_next  = b_mant;
                    ea_next  = a_be;
                    eb_next  = b_be;
                    st_next  = 1'b0;
                    if ((op == FP_ADD) || (op == FP_SUB))
                    begin
                        sign_next = add_sign;
                        m_next    = add_m;
                        be_next   = big_be;
                    end
                    else
                        sign_next = sx;
                end
            end
            FS_PRENORM:
            begin
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - EXP_W'(1);
                end
                else if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - EXP_W'(1);
                end
                else
                begin
                    prod_next = '0;
                    rem_next  = {2'b00, ma_reg};
                    cnt_next  = (op_reg == FP_MUL) ? 6'd52 : 6'd55;
                end
            end
            FS_MUL:
            begin
                prod_next = {prod_reg[104:0], 1'b0} + (mb_reg[52] ? {53'd0, ma_reg} : 106'd0);
                mb_next   = {mb_reg[51:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
            end
            FS_MULEND:
            begin
                m_next  = prod_reg[105:49];
                st_next = |prod_reg[48:0];
                be_next = ea_reg + eb_reg - EXP_W'(1023);
            end
            FS_DIV:
            begin
                rem_next  = {div_r1[53:0], 1'b0};
                prod_next = {prod_reg[104:0], div_ge};
                cnt_next  = cnt_reg - 6'd1;
            end
            FS_DIVEND:
            begin
                m_next  = {1'b0, prod_reg[55:0]};
                st_next = (rem_reg != 55'd0);
                be_next = ea_reg - eb_reg + EXP_W'(1023);
            end
            FS_NORM:
            begin
                if (norm_right)
                begin
                    m_next  = {1'b0, m_reg[56:1]};
                    st_next = st_reg | m_reg[0];
                    be_next = be_reg + EXP_W'(1);
                end
                else if (norm_collapse)
                begin
                    m_next  = '0;
                    st_next = st_reg | (m_reg != 57'd0);
                    be_next = EXP_W'(1);
                end
                else if (norm_left)
                begin
                    m_next  = {m_reg[55:0], 1'b0};
                    be_next = be_reg - EXP_W'(1);
                end
                else
                    res_next = rounded;
            end
            FS_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        sign_reg <= sign_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        m_reg    <= m_next;
        be_reg   <= be_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
    end

    assign done   = (state_reg == FS_DONE);
    assign result = res_reg;

endmodule

`default_nettype wire

>>> rtl/ssc_datapath.sv
// Datapath: term registers, operand selection, floating-point unit, count and result register.
`default_nettype none

module ssc_datapath #(
    parameter int unsigned MAX_ORDER = ssc_pkg::MAX_ORDER_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ssc_pkg::ssc_cmd_t             cmd,
    output ssc_pkg::ssc_status_t               status,
    input  wire logic                          cfg_wr_en,
    input  wire logic [63:0]                   cfg_wr_data,
    input  wire logic [63:0]                   diag_value,
    input  wire logic [63:0]                   offd_value,
    input  wire logic                          last_element,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ssc_pkg::COUNT_W-1:0]        below_count
);
    import ssc_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_ORDER < 65535) ? COUNT_W'(MAX_ORDER) : {COUNT_W{1'b1}};

    logic [63:0]        sigma_reg, sigma_next;
    logic [63:0]        tc_reg, tc_next;
    logic [63:0]        tp_reg, tp_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               mid_reg, mid_next;
    logic [63:0]        d_reg, e_reg, w_reg;
    logic               last_reg, big_reg, tiny_reg;
    logic [63:0]        t_reg, t_next;
    logic [63:0]        u_reg, u_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    // Larger magnitude of the current pair; a NaN operand selects the previous term.
    logic [63:0] mag_c, mag_p, w_new;
    logic        w_nan;

    assign mag_c = {1'b0, tc_reg[62:0]};
    assign mag_p = {1'b0, tp_reg[62:0]};
    assign w_new = (fp_is_nan(mag_c) || fp_is_nan(mag_p)) ? mag_p :
                   ((mag_c > mag_p) ? mag_c : mag_p);
    assign w_nan = fp_is_nan(w_new);

    // Operand selection for the floating-point unit.
    logic [63:0] opa, opb, fpu_res;
    logic        fpu_done;

    function automatic logic [63:0] pick(
        input opnd_t       sel,
        input logic [63:0] d,
        input logic [63:0] e,
        input logic [63:0] t,
        input logic [63:0] u,
        input logic [63:0] tc,
        input logic [63:0] tp,
        input logic [63:0] sg,
        input logic [63:0] w,
        input logic [63:0] k
    );
        logic [63:0] v;
        unique case (sel)
            OPND_D:     v = d;
            OPND_E:     v = e;
            OPND_T:     v = t;
            OPND_U:     v = u;
            OPND_TC:    v = tc;
            OPND_TP:    v = tp;
            OPND_SIGMA: v = sg;
            OPND_W:     v = w;
            OPND_K:     v = k;
            default:    v = FP_ZERO;
        endcase
        return v;
    endfunction

    logic [63:0] k_const;
    assign k_const = big_reg ? FP_SCALE_BIG : FP_SCALE_TINY;
    assign opa = pick(cmd.src_a, d_reg, e_reg, t_reg, u_reg, tc_reg, tp_reg,
                      sigma_reg, w_reg, k_const);
    assign opb = pick(cmd.src_b, d_reg, e_reg, t_reg, u_reg, tc_reg, tp_reg,
                      sigma_reg, w_reg, k_const);

    ssc_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.op),
        .a      (opa),
        .b      (opb),
        .done   (fpu_done),
        .result (fpu_res)
    );

    // Sign change between the two latest terms.
    logic change;
    assign change = (fp_lt_zero(tc_reg) && fp_ge_zero(tp_reg)) ||
                    (fp_ge_zero(tc_reg) && fp_lt_zero(tp_reg));

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // Next values of the term, count and result registers.
    always_comb
    begin
        sigma_next     = cfg_wr_en ? cfg_wr_data : sigma_reg;
        tc_next        = tc_reg;
        tp_next        = tp_reg;
        cnt_next       = cnt_reg;
        mid_next       = mid_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (fpu_done)
        begin
            unique case (cmd.dst)
                DST_T:    t_next  = fpu_res;
                DST_U:    u_next  = fpu_res;
                DST_TC:   tc_next = fpu_res;
                DST_TP:   tp_next = fpu_res;
                DST_NONE: t_next  = t_reg;
                default:  t_next  = t_reg;
            endcase
        end

        if (cmd.first_set)
        begin
            tp_next  = FP_ONE;
            tc_next  = t_reg;
            cnt_next = fp_lt_zero(t_reg) ? COUNT_W'(1) : '0;
        end

        if (cmd.advance)
        begin
            tp_next = tc_reg;
            tc_next = t_reg;
        end

        if (cmd.count_check && change && (cnt_reg < COUNT_CAP))
            cnt_next = cnt_reg + COUNT_W'(1);

        if (cmd.mark_mid)
            mid_next = 1'b1;

        if (cmd.emit)
        begin
            out_count_next = cnt_reg;
            out_valid_next = 1'b1;
            tc_next        = FP_ZERO;
            tp_next        = FP_ZERO;
            cnt_next       = '0;
            mid_next       = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= FP_ZERO;
            tc_reg        <= FP_ZERO;
            tp_reg        <= FP_ZERO;
            cnt_reg       <= '0;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sigma_reg     <= sigma_next;
            tc_reg        <= tc_next;
            tp_reg        <= tp_next;
            cnt_reg       <= cnt_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item latch, scale decision and temporaries.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg    <= diag_value;
            e_reg    <= offd_value;
            last_reg <= last_element;
            w_reg    <= w_new;
            big_reg  <= !w_nan && (w_new > FP_SCALE_BIG);
            tiny_reg <= !w_nan && (w_new < FP_SCALE_TINY);
        end
        t_reg         <= t_next;
        u_reg         <= u_next;
        out_count_reg <= out_count_next;
    end

    assign status.fpu_done   = fpu_done;
    assign status.mid        = mid_reg;
    assign status.last       = last_reg;
    assign status.need_scale = big_reg || tiny_reg;
    assign status.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign below_count = out_count_reg;

`ifndef NO_ASSERTIONS
    // The running count never passes its saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= COUNT_CAP)
        else $error("sign change count above saturation limit");

    // Emitting a result returns the block to the start of a sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (cnt_reg == '0) && !mid_reg && out_valid_reg)
        else $error("sequence state not cleared after result");

    // The first row seeds the previous term with one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.first_set |=> (tp_reg == FP_ONE) && (tc_reg == $past(t_reg)))
        else $error("first row did not seed the terms");
`endif

endmodule

`default_nettype wire

>>> rtl/ssc_ctrl.sv
// Controller state machine that sequences the per-row floating-point operations.
`default_nettype none

module ssc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output ssc_pkg::ssc_cmd_t         cmd,
    input  wire ssc_pkg::ssc_status_t status
);
    import ssc_pkg::*;

    ctrl_state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DSUB;
            end
            ST_DSUB:
            begin
                if (status.fpu_done)
                    state_next = status.mid ? ST_LEAD : ST_FIRST;
            end
            ST_FIRST:   state_next = ST_FINISH;
            ST_LEAD:
            begin
                if (status.fpu_done)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (status.fpu_done)
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (status.fpu_done)
                    state_next = ST_FRESH;
            end
            ST_FRESH:
            begin
                if (status.fpu_done)
                    state_next = ST_ADVANCE;
            end
            ST_ADVANCE: state_next = status.need_scale ? ST_SDIV : ST_COUNT;
            ST_SDIV:
            begin
                if (status.fpu_done)
                    state_next = ST_SC1;
            end
            ST_SC1:
            begin
                if (status.fpu_done)
                    state_next = ST_SC2;
            end
            ST_SC2:
            begin
                if (status.fpu_done)
                    state_next = ST_COUNT;
            end
            ST_COUNT:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.last || status.out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DSUB:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_SUB;
                cmd.src_a     = OPND_D;
                cmd.src_b     = OPND_SIGMA;
                cmd.dst       = DST_T;
            end
            ST_FIRST:   cmd.first_set = 1'b1;
            ST_LEAD:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_MUL;
                cmd.src_a     = OPND_T;
                cmd.src_b     = OPND_TC;
                cmd.dst       = DST_T;
            end
            ST_SQ:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_MUL;
                cmd.src_a     = OPND_E;
                cmd.src_b     = OPND_E;
                cmd.dst       = DST_U;
            end
            ST_TAIL:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_MUL;
                cmd.src_a     = OPND_U;
                cmd.src_b     = OPND_TP;
                cmd.dst       = DST_U;
            end
            ST_FRESH:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_SUB;
                cmd.src_a     = OPND_T;
                cmd.src_b     = OPND_U;
                cmd.dst       = DST_T;
            end
            ST_ADVANCE: cmd.advance = 1'b1;
            ST_SDIV:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_DIV;
                cmd.src_a     = OPND_K;
                cmd.src_b     = OPND_W;
                cmd.dst       = DST_U;
            end
            ST_SC1:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_MUL;
                cmd.src_a     = OPND_TC;
                cmd.src_b     = OPND_U;
                cmd.dst       = DST_TC;
            end
            ST_SC2:
            begin
                cmd.fpu_start = 1'b1;
                cmd.op        = FP_MUL;
                cmd.src_a     = OPND_TP;
                cmd.src_b     = OPND_U;
                cmd.dst       = DST_TP;
            end
            ST_COUNT:   cmd.count_check = 1'b1;
            ST_FINISH:
            begin
                cmd.mark_mid = !status.last;
                cmd.emit     = status.last && status.out_free;
            end
            default:    cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
